@@ design/rgbvga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rgbvga_pkg;

  localparam int unsigned NUM_COLORS = 16;
  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned NUM_COMPS  = 3;
  localparam int unsigned DIST_W     = 18;  // 3 * 255^2 fits in 18 bits

  // Palette level codes
  localparam logic [1:0] LVL_OFF = 2'd0;
  localparam logic [1:0] LVL_DIM = 2'd1;
  localparam logic [1:0] LVL_REG = 2'd2;
  localparam logic [1:0] LVL_MAX = 2'd3;

  // Component slots
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  localparam logic [3:0] IDX_BROWN = 4'd6;

  typedef logic [DIST_W-1:0] dist_t;
  typedef dist_t [NUM_COLORS-1:0] dist_vec_t;

  typedef struct packed {
    dist_t      dsq;
    logic [3:0] idx;
  } cand_t;

  function automatic logic [7:0] lvl_value(input logic [1:0] code);
    logic [7:0] v;
    case (code)
      LVL_OFF: v = 8'h00;
      LVL_DIM: v = 8'h55;
      LVL_REG: v = 8'hAA;
      LVL_MAX: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Level code of one component of a palette entry (IRGB index)
  function automatic logic [1:0] pal_code(input logic [3:0] idx, input logic [1:0] comp);
    logic       on;
    logic [1:0] code;
    case (comp)
      COMP_RED:   on = idx[2];
      COMP_GREEN: on = idx[1];
      COMP_BLUE:  on = idx[0];
      default:    on = 1'b0;
    endcase
    if (idx[3]) begin
      code = on ? LVL_MAX : LVL_DIM;
    end else begin
      code = on ? LVL_REG : LVL_OFF;
    end
    // brown: green at half level
    if (idx == IDX_BROWN && comp == COMP_GREEN) begin
      code = LVL_DIM;
    end
    return code;
  endfunction

endpackage
`default_nettype wire

@@ design/rgbvga_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rgbvga_dist
  import rgbvga_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       dark_only,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output dist_vec_t       dn_dist
);

  // stage 1: absolute differences to each level
  logic                                   v1;
  logic                                   dark1;
  logic [NUM_COMPS-1:0][NUM_LEVELS-1:0][7:0]  diff1;
  // stage 2: squares
  logic                                   v2;
  logic                                   dark2;
  logic [NUM_COMPS-1:0][NUM_LEVELS-1:0][15:0] sq2;
  // stage 3: distances
  logic                                   v3;
  dist_vec_t                              dist3;

  logic r1, r2, r3;
  logic [NUM_COMPS-1:0][7:0] pix;
  logic [NUM_COMPS-1:0][NUM_LEVELS-1:0][7:0] diff_next;
  dist_vec_t dist_next;

  assign r3 = !v3 || dn_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  assign pix[COMP_RED]   = red;
  assign pix[COMP_GREEN] = green;
  assign pix[COMP_BLUE]  = blue;

  always_comb begin
    logic [7:0] lv;
    for (int c = 0; c < NUM_COMPS; c++) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        lv = lvl_value(2'(l));
        diff_next[c][l] = (pix[c] >= lv) ? (pix[c] - lv) : (lv - pix[c]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      if (dark2 && i >= NUM_COLORS / 2) begin
        dist_next[i] = '1;  // never beats a dark candidate
      end else begin
        dist_next[i] = DIST_W'(sq2[COMP_RED][pal_code(4'(i), COMP_RED)])
                     + DIST_W'(sq2[COMP_GREEN][pal_code(4'(i), COMP_GREEN)])
                     + DIST_W'(sq2[COMP_BLUE][pal_code(4'(i), COMP_BLUE)]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      diff1 <= diff_next;
      dark1 <= dark_only;
    end
    if (r2 && v1) begin
      for (int c = 0; c < NUM_COMPS; c++) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          sq2[c][l] <= 16'(diff1[c][l]) * 16'(diff1[c][l]);
        end
      end
      dark2 <= dark1;
    end
    if (r3 && v2) begin
      dist3 <= dist_next;
    end
  end

  assign dn_valid = v3;
  assign dn_dist  = dist3;

endmodule
`default_nettype wire

@@ design/rgbvga_min.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rgbvga_min
  import rgbvga_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire dist_vec_t up_dist,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output logic [3:0]     color_index
);

  localparam int unsigned GROUPS = NUM_COLORS / 4;

  // lower index kept on a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.dsq < a.dsq) ? b : a;
  endfunction

  logic            v4;
  cand_t [GROUPS-1:0] best4;
  logic            v5;
  logic [3:0]      idx5;

  logic r4, r5;
  cand_t [GROUPS-1:0] best_next;
  cand_t              final_next;

  assign r5 = !v5 || dn_ready;
  assign r4 = !v4 || r5;
  assign up_ready = r4;

  always_comb begin
    cand_t a, b, c, d;
    for (int g = 0; g < GROUPS; g++) begin
      a = '{dsq: up_dist[4*g],   idx: 4'(4*g)};
      b = '{dsq: up_dist[4*g+1], idx: 4'(4*g+1)};
      c = '{dsq: up_dist[4*g+2], idx: 4'(4*g+2)};
      d = '{dsq: up_dist[4*g+3], idx: 4'(4*g+3)};
      best_next[g] = pick(pick(a, b), pick(c, d));
    end
  end

  assign final_next = pick(pick(best4[0], best4[1]), pick(best4[2], best4[3]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r4) v4 <= up_valid;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && up_valid) best4 <= best_next;
    if (r5 && v4)       idx5  <= final_next.idx;
  end

  assign dn_valid    = v5;
  assign color_index = idx5;

endmodule
`default_nettype wire

@@ design/rgb_to_vga_nearest_color.sv @@
// Nearest VGA 16-colour palette index for a 24-bit RGB pixel.
// Pixel channel: pix_valid / pix_ready with red, green, blue (8 bits each);
//   an item is taken on an edge with both high.
// Result channel: res_valid / res_ready with color_index (IRGB, 4 bits).
// Config channel: cfg_valid / cfg_ready with cfg_data = dark_only; cfg_ready
//   is always high. With dark_only set only indices 0..7 are candidates.
//   Write it only with the pipeline empty.
// Distance is squared Euclidean in RGB; on a tie the lower index wins.
// Pipeline of five register stages: level differences, squares, per-colour
//   sums, 16-to-4 minimum, 4-to-1 minimum into the output register.
// Throughput: one item per cycle while res_ready keeps up, set by the
//   five-stage pipeline with a valid bit per stage.
// Receiver stall: stages fill behind the held output; pix_ready drops once
//   every stage holds an item, nothing is lost or repeated.
// Reset (rst, synchronous): all stages empty, dark_only cleared.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_vga_nearest_color
  import rgbvga_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pix_valid,
  output logic            pix_ready,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [3:0]      color_index,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);

  logic      dark_only;
  logic      mid_valid;
  logic      mid_ready;
  dist_vec_t mid_dist;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dark_only <= cfg_data;
    end
  end

  // stages 1-3: sixteen distances
  rgbvga_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (pix_valid),
    .up_ready  (pix_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .dark_only (dark_only),
    .dn_valid  (mid_valid),
    .dn_ready  (mid_ready),
    .dn_dist   (mid_dist)
  );

  // stages 4-5: minimum search, output register
  rgbvga_min u_min (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (mid_valid),
    .up_ready    (mid_ready),
    .up_dist     (mid_dist),
    .dn_valid    (res_valid),
    .dn_ready    (res_ready),
    .color_index (color_index)
  );

`ifndef SYNTHESIS
  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // with the output stage free every stage can move, so input must be ready
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("pixel input stalled with empty output stage");

  // the middle hand-off only stalls when the output side is held
  a_mid_stall: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !mid_ready) |-> (res_valid && !res_ready))
    else $error("internal stall without output back-pressure");
`endif

endmodule
`default_nettype wire

@@ tb/sv/nearest_color_checker.sv @@
`timescale 1ns / 1ps
module nearest_color_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  input  logic       pix_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic [3:0] color_index,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  output int         pending,
  output int         fail_count
);

  localparam logic [7:0] LV_OFF = 8'h00;
  localparam logic [7:0] LV_DIM = 8'h55;
  localparam logic [7:0] LV_REG = 8'hAA;
  localparam logic [7:0] LV_MAX = 8'hFF;

  // {red, green, blue} per IRGB index
  localparam logic [23:0] PALETTE [16] = '{
    {LV_OFF, LV_OFF, LV_OFF}, {LV_OFF, LV_OFF, LV_REG},
    {LV_OFF, LV_REG, LV_OFF}, {LV_OFF, LV_REG, LV_REG},
    {LV_REG, LV_OFF, LV_OFF}, {LV_REG, LV_OFF, LV_REG},
    {LV_REG, LV_DIM, LV_OFF}, {LV_REG, LV_REG, LV_REG},
    {LV_DIM, LV_DIM, LV_DIM}, {LV_DIM, LV_DIM, LV_MAX},
    {LV_DIM, LV_MAX, LV_DIM}, {LV_DIM, LV_MAX, LV_MAX},
    {LV_MAX, LV_DIM, LV_DIM}, {LV_MAX, LV_DIM, LV_MAX},
    {LV_MAX, LV_MAX, LV_DIM}, {LV_MAX, LV_MAX, LV_MAX}
  };

  logic       dark_only_q;
  logic [3:0] index_q [$];
  logic [3:0] want;

  // strict compare keeps the lowest index on a tie
  function automatic logic [3:0] nearest_vga_index(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic dark);
    int unsigned best_d;
    int unsigned d2;
    int          dr;
    int          dg;
    int          db;
    int          last;
    logic [3:0]  best;
    best   = 4'd0;
    best_d = 32'hFFFF_FFFF;
    last   = dark ? 7 : 15;
    for (int i = 0; i <= last; i++) begin
      dr = int'(r) - int'(PALETTE[i][23:16]);
      dg = int'(g) - int'(PALETTE[i][15:8]);
      db = int'(b) - int'(PALETTE[i][7:0]);
      d2 = dr * dr + dg * dg + db * db;
      if (d2 < best_d) begin
        best_d = d2;
        best   = i[3:0];
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dark_only_q <= 1'b0;
      index_q.delete();
      pending     <= 0;
      fail_count  <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (index_q.size() == 0) begin
          $error("color_index: expected none, actual %0d", color_index);
          fail_count <= fail_count + 1;
        end else begin
          want = index_q.pop_front();
          if (color_index !== want) begin
            $error("color_index: expected %0d, actual %0d", want, color_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pix_valid && pix_ready) begin
        index_q.push_back(nearest_vga_index(red, green, blue, dark_only_q));
      end
      if (cfg_valid && cfg_ready) begin
        dark_only_q <= cfg_data;
      end
      pending <= index_q.size();
    end
  end

endmodule

@@ tb/sv/tb_rgb_to_vga_nearest_color.sv @@
`timescale 1ns / 1ps
module tb_rgb_to_vga_nearest_color;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_LONG} rx_mode_e;

  localparam int NUM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 322;
  localparam int DRAIN_CYCLES   = 8;   // margin after the last outstanding result

  // palette levels, and points midway between neighbouring levels mixed with levels 55, AA, FF
  localparam logic [7:0] LEVELS [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};
  localparam logic [7:0] MIDWAY [6] = '{8'h2A, 8'h55, 8'h7F, 8'hAA, 8'hD4, 8'hFF};

  // directed pixels {red, green, blue}
  localparam logic [23:0] DIRECTED [24] = '{
    // every palette entry, exact
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
    // equal distance to black and a dark primary: lower index must win
    24'h550000, 24'h005500, 24'h000055,
    // pure primaries at full scale and mid grey
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h7F7F7F, 24'h808080
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       pix_valid = 1'b0;
  logic [7:0] red       = 8'h00;
  logic [7:0] green     = 8'h00;
  logic [7:0] blue      = 8'h00;
  logic       res_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       pix_ready;
  logic       res_valid;
  logic [3:0] color_index;
  logic       cfg_ready;

  int pending;
  int fail_count;
  int burst_left = 0;

  rx_mode_e rx_mode    = RX_ALWAYS;
  int       rx_cycles  = 0;
  int       rx_hold    = 0;

  rgb_to_vga_nearest_color i_dut (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .color_index (color_index),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Watches all three channels, predicts each pixel's index and scores the results
  nearest_color_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .color_index (color_index),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: each stall pattern holds until its random countdown runs out, then a new one
  // is drawn. The long-stall pattern lets the pipeline fill and back-pressure
  // the pixel side; the always-ready pattern gives stretches with no stalls.
  always @(posedge clk) begin
    if (rx_cycles == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
      rx_cycles <= $urandom_range(100, 400);
    end else begin
      rx_cycles <= rx_cycles - 1;
    end
    case (rx_mode)
      RX_ALWAYS: res_ready <= 1'b1;
      RX_RANDOM: res_ready <= $urandom_range(0, 1);
      RX_SPARSE: res_ready <= (rx_cycles % 3 == 0);
      RX_LONG: begin
        if (rx_hold != 0) begin
          res_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          res_ready <= 1'b0;
          rx_hold   <= $urandom_range(5, 40);
        end else begin
          res_ready <= 1'b1;
        end
      end
      default: res_ready <= 1'b1;
    endcase
  end

  // One pixel item. Bursts of random length; between bursts valid may drop for a
  // random gap. Back-to-back items keep valid high, never toggling it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_valid <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (!pix_ready);
  endtask

  // Mix of fully random values, values near a palette level and values near
  // the half-way points where the nearest colour flips or ties.
  function automatic logic [7:0] pick_comp();
    int v;
    case ($urandom_range(0, 2))
      0:       v = int'($urandom_range(0, 255));
      1:       v = int'(LEVELS[$urandom_range(0, 3)]) + int'($urandom_range(0, 8)) - 4;
      default: v = int'(MIDWAY[$urandom_range(0, 5)]) + int'($urandom_range(0, 2)) - 1;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = pick_comp();
    g = pick_comp();
    b = pick_comp();
    send_pixel(r, g, b);
  endtask

  // Stop the pixel side and wait for every outstanding result, plus a margin
  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dark_only(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full palette first, reset value written explicitly
    write_dark_only(1'b0);
    foreach (DIRECTED[k]) begin
      send_pixel(DIRECTED[k][23:16], DIRECTED[k][15:8], DIRECTED[k][7:0]);
    end

    // random phases, alternating dark-only on and off
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_dark_only(ph % 2 == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_pixel();
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: reports an error and stops the run if it has not finished
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
